// File: hdl/pdm_pkg.sv
// ----------------------------------------------------------------------------
// pdm_pkg
// Shared types, constants and helpers of the pedometer step detector.
// ----------------------------------------------------------------------------
package pdm_pkg;

	localparam int SAMPLE_W = 20;
	localparam int AVG_W    = 16;
	localparam int CNT_W    = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam int WINDOW_LEN_DEF = 4;

	// Division by ten as a multiply by a reciprocal: exact for all 20-bit inputs.
	localparam logic [SAMPLE_W-1:0] DIV10_RECIP = 20'd838861;
	localparam int                  DIV10_SHIFT = 23;

	localparam logic [AVG_W-1:0] SWING_LIMIT = 16'd10000;

	localparam logic [15:0]      AMP_THRESHOLD_RST      = 16'd300;
	localparam logic [CNT_W-1:0] INTERVAL_THRESHOLD_RST = 8'd3;
	localparam logic [CNT_W-1:0] START_STEPS_RST        = 8'd4;
	localparam logic [CNT_W-1:0] IDLE_LIMIT_RST         = 8'd50;
	localparam logic [CNT_W-1:0] MISS_LIMIT_RST         = 8'd5;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_AMP_THRESHOLD      = 3'd0,
		CFG_INTERVAL_THRESHOLD = 3'd1,
		CFG_START_STEPS        = 3'd2,
		CFG_IDLE_LIMIT         = 3'd3,
		CFG_MISS_LIMIT         = 3'd4
	} cfg_idx_t;

	typedef struct packed {
		logic [15:0]      amp_threshold;
		logic [CNT_W-1:0] interval_threshold;
		logic [CNT_W-1:0] start_steps;
		logic [CNT_W-1:0] idle_limit;
		logic [CNT_W-1:0] miss_limit;
	} cfg_t;

	// Detector to qualifier: step found and the miss count after this request.
	typedef struct packed {
		logic             step;
		logic [CNT_W-1:0] miss;
	} det_t;

	// Qualifier back to detector: overrides applied to detector state.
	typedef struct packed {
		logic clr_miss;
		logic clr_seek;
	} qual_ctl_t;

	function automatic logic [CNT_W-1:0] sat_inc8(input logic [CNT_W-1:0] a);
		logic [CNT_W-1:0] r;
		r = (a == {CNT_W{1'b1}}) ? a : a + CNT_W'(1);
		return r;
	endfunction

	function automatic logic [CNT_W-1:0] sat_add8(input logic [CNT_W-1:0] a,
			input logic [CNT_W-1:0] b);
		logic [CNT_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
	endfunction

endpackage

// File: hdl/pdm_prefilter.sv
// ----------------------------------------------------------------------------
// pdm_prefilter
// Input register, scaling by one tenth with saturation, and the running
// window sum of the last WINDOW_LEN scaled samples.
// ----------------------------------------------------------------------------
module pdm_prefilter #(
	parameter int WINDOW_LEN = pdm_pkg::WINDOW_LEN_DEF
) (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  logic                                         load_s1,
	input  logic                                         load_s2,
	input  logic [pdm_pkg::SAMPLE_W-1:0]                 sample,
	input  logic                                         last_of_batch,
	output logic [pdm_pkg::AVG_W+$clog2(WINDOW_LEN)-1:0] sum_s2,
	output logic                                         last_s2
);
	import pdm_pkg::*;

	localparam int SUM_W  = AVG_W + $clog2(WINDOW_LEN);
	localparam int PROD_W = 2 * SAMPLE_W;
	localparam int Q_W    = PROD_W - DIV10_SHIFT;

	logic [SAMPLE_W-1:0] raw_s1;
	logic                last_s1;
	logic [PROD_W-1:0]   prod;
	logic [Q_W-1:0]      quot;
	logic [AVG_W-1:0]    scaled;
	logic [AVG_W-1:0]    line_q [WINDOW_LEN];
	logic [SUM_W-1:0]    total_q;
	logic [SUM_W-1:0]    total_n;

	always_ff @(posedge clk) begin
		if (load_s1) begin
			raw_s1  <= sample;
			last_s1 <= last_of_batch;
		end
		if (load_s2) begin
			sum_s2  <= total_n;
			last_s2 <= last_s1;
		end
	end

	always_comb begin
		prod   = {{SAMPLE_W{1'b0}}, raw_s1} * {{SAMPLE_W{1'b0}}, DIV10_RECIP};
		quot   = prod[PROD_W-1:DIV10_SHIFT];
		scaled = (quot > Q_W'({AVG_W{1'b1}})) ? {AVG_W{1'b1}} : quot[AVG_W-1:0];
		// The oldest sample leaves the window as the new one enters.
		total_n = total_q + SUM_W'(scaled) - SUM_W'(line_q[WINDOW_LEN-1]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WINDOW_LEN; i++) begin
				line_q[i] <= '0;
			end
			total_q <= '0;
		end else if (load_s2) begin
			line_q[0] <= scaled;
			for (int i = 1; i < WINDOW_LEN; i++) begin
				line_q[i] <= line_q[i-1];
			end
			total_q <= total_n;
		end
	end

endmodule

// File: hdl/pdm_detect.sv
// ----------------------------------------------------------------------------
// pdm_detect
// Moving average from the window sum, and the trough then peak search over
// the three latest distinct averages.
// ----------------------------------------------------------------------------
module pdm_detect #(
	parameter int WINDOW_LEN = pdm_pkg::WINDOW_LEN_DEF
) (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  logic                                         load_out,
	input  logic [pdm_pkg::AVG_W+$clog2(WINDOW_LEN)-1:0] sum_s2,
	input  pdm_pkg::cfg_t                                cfg,
	input  pdm_pkg::qual_ctl_t                           ctl,
	output pdm_pkg::det_t                                det
);
	import pdm_pkg::*;

	localparam int SUM_W = AVG_W + $clog2(WINDOW_LEN);
	localparam int RSH   = SUM_W + $clog2(WINDOW_LEN) + 1;
	typedef logic [RSH:0] recip_t;
	localparam recip_t RECIP = recip_t'(((64'd1 << RSH) + WINDOW_LEN - 1) / WINDOW_LEN);

	logic [SUM_W+RSH:0] prod;
	logic [AVG_W-1:0]   avg;
	logic [AVG_W-1:0]   ra_q [3];
	logic [AVG_W-1:0]   ra_n [3];
	logic [AVG_W-1:0]   trough_q;
	logic [AVG_W-1:0]   trough_n;
	logic [AVG_W-1:0]   tr;
	logic [AVG_W-1:0]   swing;
	logic               seek_q;
	logic               seek_n;
	logic [CNT_W-1:0]   since_q;
	logic [CNT_W-1:0]   since_n;
	logic [CNT_W-1:0]   miss_q;
	logic [CNT_W-1:0]   miss_n;
	logic               step;

	always_comb begin
		prod = {{(RSH+1){1'b0}}, sum_s2} * {{SUM_W{1'b0}}, RECIP};
		avg  = prod[RSH +: AVG_W];

		ra_n     = ra_q;
		trough_n = trough_q;
		seek_n   = seek_q;
		since_n  = since_q;
		miss_n   = miss_q;
		step     = 1'b0;
		tr       = trough_q;
		swing    = '0;

		// A repeated average leaves the detector state unchanged, apart from the qualifier's overrides.
		if (avg != ra_q[0]) begin
			ra_n[0] = avg;
			ra_n[1] = ra_q[0];
			ra_n[2] = ra_q[1];
			since_n = sat_inc8(since_q);
			if (!seek_q) begin
				if (ra_q[0] < ra_q[1] && ra_q[0] < avg) begin
					seek_n   = 1'b1;
					trough_n = ra_q[0];
				end
			end else begin
				tr       = (avg < trough_q) ? ra_q[0] : trough_q;
				trough_n = tr;
				if (ra_q[0] > ra_q[1] && ra_q[0] > avg) begin
					swing = ra_q[0] - tr;
					priority if (swing > SWING_LIMIT) begin
						seek_n = 1'b0;
					end else if (swing > cfg.amp_threshold &&
							since_n > cfg.interval_threshold) begin
						since_n = '0;
						seek_n  = 1'b0;
						miss_n  = '0;
						step    = 1'b1;
					end else begin
						miss_n = sat_inc8(miss_q);
					end
				end
			end
		end
	end

	assign det.step = step;
	assign det.miss = miss_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				ra_q[i] <= '0;
			end
			trough_q <= '0;
			seek_q   <= 1'b0;
			since_q  <= '0;
			miss_q   <= '0;
		end else if (load_out) begin
			ra_q     <= ra_n;
			trough_q <= trough_n;
			seek_q   <= ctl.clr_seek ? 1'b0 : seek_n;
			since_q  <= since_n;
			miss_q   <= ctl.clr_miss ? '0 : miss_n;
		end
	end

endmodule

// File: hdl/pdm_qualify.sv
// ----------------------------------------------------------------------------
// pdm_qualify
// Walk qualifier: holds steps until enough are pending, keeps the batch
// total, and drives the result register.
// ----------------------------------------------------------------------------
module pdm_qualify (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      load_out,
	input  logic                      last_s2,
	input  pdm_pkg::cfg_t             cfg,
	input  pdm_pkg::det_t             det,
	output pdm_pkg::qual_ctl_t        ctl,
	output logic [pdm_pkg::CNT_W-1:0] steps_now,
	output logic [pdm_pkg::CNT_W-1:0] batch_steps,
	output logic                      walking
);
	import pdm_pkg::*;

	logic [CNT_W-1:0] idle_q;
	logic [CNT_W-1:0] idle_n;
	logic [CNT_W-1:0] pend_q;
	logic [CNT_W-1:0] pend_a;
	logic [CNT_W-1:0] pend_b;
	logic [CNT_W-1:0] pend_n;
	logic             walk_q;
	logic             walk_n;
	logic [CNT_W-1:0] batch_q;
	logic [CNT_W-1:0] batch_n;
	logic [CNT_W-1:0] added;
	logic             quit;

	always_comb begin
		idle_n  = det.step ? '0 : sat_inc8(idle_q);
		pend_a  = det.step ? sat_inc8(pend_q) : pend_q;
		quit    = idle_n >= cfg.idle_limit || det.miss >= cfg.miss_limit;
		pend_b  = quit ? '0 : pend_a;
		pend_n  = pend_a;
		walk_n  = walk_q;
		batch_n = batch_q;
		added   = '0;
		ctl     = '0;
		if (!walk_q) begin
			pend_n = pend_b;
			if (pend_b >= cfg.start_steps) begin
				// Walking starts: the held steps are credited all at once.
				walk_n       = 1'b1;
				added        = pend_b;
				batch_n      = sat_add8(batch_q, pend_b);
				pend_n       = '0;
				ctl.clr_miss = 1'b1;
			end
		end else if (quit) begin
			pend_n       = '0;
			batch_n      = '0;
			walk_n       = 1'b0;
			ctl.clr_seek = 1'b1;
		end else begin
			added   = {{(CNT_W-1){1'b0}}, det.step};
			batch_n = sat_add8(batch_q, added);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_q  <= '0;
			pend_q  <= '0;
			walk_q  <= 1'b0;
			batch_q <= '0;
		end else if (load_out) begin
			idle_q  <= idle_n;
			pend_q  <= pend_n;
			walk_q  <= walk_n;
			batch_q <= last_s2 ? '0 : batch_n;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			steps_now   <= added;
			batch_steps <= batch_n;
		end
	end

	// The phase register changes only together with the result register.
	assign walking = walk_q;

endmodule

// File: hdl/pedometer_step_detector_core.sv
// ----------------------------------------------------------------------------
// pedometer_step_detector_core
// Step counter over accelerometer magnitude samples. Each request on the
// input channel (sample, last_of_batch) produces exactly one request on the
// output channel (steps_now, batch_steps, walking), in order.
// A request passes the input register, then scaling and window sum, then
// averaging, detection and qualification into the result register. One
// request is taken per cycle while in_stall is low.
// When out_stall is high the result holds and the pipeline keeps filling its
// empty stages; in_stall rises only once all three stages hold requests.
// Thresholds are written via cfg_we/cfg_index/cfg_data, by the user only while
// the block is empty, which it does not enforce; unknown indexes are ignored.
// Reset clears window, detector and qualifier state; loads default thresholds.
// ----------------------------------------------------------------------------
module pedometer_step_detector_core #(
	parameter int WINDOW_LEN = pdm_pkg::WINDOW_LEN_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [pdm_pkg::SAMPLE_W-1:0]   sample,
	input  logic                           last_of_batch,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [pdm_pkg::CNT_W-1:0]      steps_now,
	output logic [pdm_pkg::CNT_W-1:0]      batch_steps,
	output logic                           walking,
	input  logic                           cfg_we,
	input  logic [pdm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pdm_pkg::CFG_DATA_W-1:0] cfg_data
);
	import pdm_pkg::*;

	localparam int SUM_W = AVG_W + $clog2(WINDOW_LEN);

	cfg_t             cfg_q;
	logic             v_s1_q;
	logic             v_s2_q;
	logic             out_valid_q;
	logic             load_s1;
	logic             load_s2;
	logic             load_out;
	logic [SUM_W-1:0] sum_s2;
	logic             last_s2;
	det_t             det;
	qual_ctl_t        ctl;

	// A stage can take a request when it is empty or passes its own on.
	always_comb begin
		load_out = v_s2_q && (!out_valid_q || !out_stall);
		load_s2  = v_s1_q && (!v_s2_q || load_out);
		in_stall = v_s1_q && !load_s2;
		load_s1  = in_valid && !in_stall;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1_q      <= 1'b0;
			v_s2_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_s1) begin
				v_s1_q <= 1'b1;
			end else if (load_s2) begin
				v_s1_q <= 1'b0;
			end
			if (load_s2) begin
				v_s2_q <= 1'b1;
			end else if (load_out) begin
				v_s2_q <= 1'b0;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.amp_threshold      <= AMP_THRESHOLD_RST;
			cfg_q.interval_threshold <= INTERVAL_THRESHOLD_RST;
			cfg_q.start_steps        <= START_STEPS_RST;
			cfg_q.idle_limit         <= IDLE_LIMIT_RST;
			cfg_q.miss_limit         <= MISS_LIMIT_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_AMP_THRESHOLD: begin
					cfg_q.amp_threshold <= cfg_data;
				end
				CFG_INTERVAL_THRESHOLD: begin
					cfg_q.interval_threshold <= cfg_data[CNT_W-1:0];
				end
				CFG_START_STEPS: begin
					cfg_q.start_steps <= cfg_data[CNT_W-1:0];
				end
				CFG_IDLE_LIMIT: begin
					cfg_q.idle_limit <= cfg_data[CNT_W-1:0];
				end
				CFG_MISS_LIMIT: begin
					cfg_q.miss_limit <= cfg_data[CNT_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	pdm_prefilter #(
		.WINDOW_LEN(WINDOW_LEN)
	) u_prefilter (
		.clk          (clk),
		.arst_n       (arst_n),
		.load_s1      (load_s1),
		.load_s2      (load_s2),
		.sample       (sample),
		.last_of_batch(last_of_batch),
		.sum_s2       (sum_s2),
		.last_s2      (last_s2)
	);

	pdm_detect #(
		.WINDOW_LEN(WINDOW_LEN)
	) u_detect (
		.clk     (clk),
		.arst_n  (arst_n),
		.load_out(load_out),
		.sum_s2  (sum_s2),
		.cfg     (cfg_q),
		.ctl     (ctl),
		.det     (det)
	);

	pdm_qualify u_qualify (
		.clk        (clk),
		.arst_n     (arst_n),
		.load_out   (load_out),
		.last_s2    (last_s2),
		.cfg        (cfg_q),
		.det        (det),
		.ctl        (ctl),
		.steps_now  (steps_now),
		.batch_steps(batch_steps),
		.walking    (walking)
	);

endmodule
